### src/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg: shared types and constants for the indexed list engine
// Command codes, status codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ilist_pkg;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default list capacity
   localparam int DEPTH_DEFAULT = 16;

   // Command codes (code 7 is unused and does nothing)
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_READ    = 3'd2,
      CMD_REPLACE = 3'd3,
      CMD_SWAP    = 3'd4,
      CMD_FIND    = 3'd5,
      CMD_CLEAR   = 3'd6
   } cmd_type;

   // Status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // What every cell does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ROTATE,
      CELL_WRITE
   } cell_mode_type;

   // Control word broadcast to the cell chain
   typedef struct packed {
      cell_mode_type     mode;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  other_position;
      logic              wr_b_en;
      logic [DATA_W-1:0] wr_a;
      logic [DATA_W-1:0] wr_b;
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/ilist_cell.sv
// ----------------------------------------------------------------------------
// ilist_cell: one storage slot of the list chain
// Holds one entry; shifts from its left or right neighbor, rotates toward
// the head, or takes a broadcast write when its index matches.
// ----------------------------------------------------------------------------
`default_nettype none

module ilist_cell #(
   parameter int DEPTH = ilist_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  wire logic                           clock,
   input  wire ilist_pkg::cell_ctl_type        ctl,
   input  wire logic [ilist_pkg::DATA_W-1:0]   prev_data,
   input  wire logic [ilist_pkg::DATA_W-1:0]   next_data,
   output logic      [ilist_pkg::DATA_W-1:0]   entry
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CMP_W  = (IDX_W > ilist_pkg::POS_W) ? IDX_W : ilist_pkg::POS_W;
   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic [ilist_pkg::DATA_W-1:0] entry_ff;
   logic [ilist_pkg::DATA_W-1:0] entry_in;
   logic [CMP_W-1:0]             pos_w;
   logic [CMP_W-1:0]             pos2_w;

   assign pos_w  = CMP_W'(ctl.position);
   assign pos2_w = CMP_W'(ctl.other_position);

   // next entry value
   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         ilist_pkg::CELL_INSERT: begin
            // new value lands at position, later entries move up one
            if (MY_IDX == pos_w) begin
               entry_in = ctl.wr_a;
            end else if (MY_IDX > pos_w) begin
               entry_in = prev_data;
            end
         end
         ilist_pkg::CELL_REMOVE: begin
            // entries from position on move down one
            if (MY_IDX >= pos_w) begin
               entry_in = next_data;
            end
         end
         ilist_pkg::CELL_ROTATE: begin
            entry_in = next_data;
         end
         ilist_pkg::CELL_WRITE: begin
            if (MY_IDX == pos_w) begin
               entry_in = ctl.wr_a;
            end
            if (ctl.wr_b_en && (MY_IDX == pos2_w)) begin
               entry_in = ctl.wr_b;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // storage, no reset: contents are undefined until written
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

### src/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of signed 32-bit values in a cell chain
// Insert, remove, read, replace, swap, find and clear on a list of up to
// DEPTH entries held in a row of shifting cells.
//
//   channel | ports        | direction | content
//   --------+--------------+-----------+--------------------------------------
//   req     | req_*        | in        | cmd, position, other_position, value
//   rsp     | rsp_*        | out       | read_value, found, status, count,
//           |              |           | is_empty
//
// Insert, remove, replace, clear, unused codes and any bad index finish in
// the accept cycle: the result is registered at that edge.
// Read, find and swap rotate the whole chain once past the head cell:
// DEPTH + 1 cycles from accept to result, set by the chain length.
// A new item is taken when the engine is idle and the result register is
// empty or being emptied in the same cycle. Reset (synchronous) empties the
// list and the result register; entry storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine #(
   parameter int DEPTH = ilist_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic        [ilist_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic        [ilist_pkg::POS_W-1:0]    req_position,
   input  wire logic        [ilist_pkg::POS_W-1:0]    req_other_position,
   input  wire logic signed [ilist_pkg::DATA_W-1:0]   req_value,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed      [ilist_pkg::DATA_W-1:0]   rsp_read_value,
   output logic                                       rsp_found,
   output logic             [ilist_pkg::STATUS_W-1:0] rsp_status,
   output logic             [ilist_pkg::COUNT_W-1:0]  rsp_count,
   output logic                                       rsp_is_empty
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int STEP_W = $clog2(DEPTH);
   localparam int CMP_W  = (CNT_W > ilist_pkg::POS_W) ? CNT_W : ilist_pkg::POS_W;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // control state
   state_type                    state_ff,     state_in;
   logic [CNT_W-1:0]             cnt_ff,       cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   // item and scan payload
   logic [STEP_W-1:0]            step_ff,      step_in;
   logic [ilist_pkg::CMD_W-1:0]  cmd_ff,       cmd_in;
   logic [ilist_pkg::POS_W-1:0]  pos_ff,       pos_in;
   logic [ilist_pkg::POS_W-1:0]  pos2_ff,      pos2_in;
   logic [ilist_pkg::DATA_W-1:0] value_ff,     value_in;
   logic [ilist_pkg::DATA_W-1:0] a_ff,         a_in;
   logic [ilist_pkg::DATA_W-1:0] b_ff,         b_in;
   logic                         found_ff,     found_in;
   // result register
   logic signed [ilist_pkg::DATA_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic                                  rsp_found_ff,      rsp_found_in;
   logic        [ilist_pkg::STATUS_W-1:0] rsp_status_ff,     rsp_status_in;
   logic        [ilist_pkg::COUNT_W-1:0]  rsp_count_ff,      rsp_count_in;
   logic                                  rsp_is_empty_ff,   rsp_is_empty_in;

   ilist_pkg::cell_ctl_type      ctl;
   logic [ilist_pkg::DATA_W-1:0] entry_q [DEPTH];
   logic [ilist_pkg::DATA_W-1:0] head;

   logic             accept;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] req_pos_w;
   logic [CMP_W-1:0] req_pos2_w;
   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] pos2_w;
   logic [CMP_W-1:0] step_w;
   logic             req_pos_ok;
   logic             req_pos2_ok;
   logic             is_full;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign head       = entry_q[0];

   assign cnt_w       = CMP_W'(cnt_ff);
   assign req_pos_w   = CMP_W'(req_position);
   assign req_pos2_w  = CMP_W'(req_other_position);
   assign pos_w       = CMP_W'(pos_ff);
   assign pos2_w      = CMP_W'(pos2_ff);
   assign step_w      = CMP_W'(step_ff);
   assign req_pos_ok  = req_pos_w < cnt_w;
   assign req_pos2_ok = req_pos2_w < cnt_w;
   assign is_full     = cnt_ff == CNT_W'(DEPTH);

   // cell chain
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [ilist_pkg::DATA_W-1:0] prev_data;
      logic [ilist_pkg::DATA_W-1:0] next_data;

      if (gi == 0) begin : g_first
         assign prev_data = entry_q[0];
      end else begin : g_inner_prev
         assign prev_data = entry_q[gi-1];
      end

      // last cell wraps to the head so the chain can rotate
      if (gi == DEPTH - 1) begin : g_last
         assign next_data = entry_q[0];
      end else begin : g_inner_next
         assign next_data = entry_q[gi+1];
      end

      ilist_cell #(
         .DEPTH (DEPTH),
         .INDEX (gi)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .prev_data (prev_data),
         .next_data (next_data),
         .entry     (entry_q[gi])
      );
   end

   // command sequencing and result formation
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      step_in           = step_ff;
      cmd_in            = cmd_ff;
      pos_in            = pos_ff;
      pos2_in           = pos2_ff;
      value_in          = value_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      found_in          = found_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_is_empty_in   = rsp_is_empty_ff;

      ctl.mode           = ilist_pkg::CELL_HOLD;
      ctl.position       = req_position;
      ctl.other_position = req_other_position;
      ctl.wr_b_en        = 1'b0;
      ctl.wr_a           = req_value;
      ctl.wr_b           = req_value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               pos_in   = req_position;
               pos2_in  = req_other_position;
               value_in = req_value;
               step_in  = '0;
               found_in = 1'b0;

               // default: finished in this cycle
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = '0;
               rsp_found_in      = 1'b0;
               rsp_status_in     = ilist_pkg::STATUS_OK;

               case (req_cmd)
                  ilist_pkg::CMD_INSERT: begin
                     if (req_pos_w > cnt_w) begin
                        rsp_status_in = ilist_pkg::STATUS_RANGE;
                     end else if (is_full) begin
                        rsp_status_in = ilist_pkg::STATUS_FULL;
                     end else begin
                        ctl.mode = ilist_pkg::CELL_INSERT;
                        cnt_in   = cnt_ff + CNT_W'(1);
                     end
                  end
                  ilist_pkg::CMD_REMOVE: begin
                     if (!req_pos_ok) begin
                        rsp_status_in = ilist_pkg::STATUS_RANGE;
                     end else begin
                        ctl.mode = ilist_pkg::CELL_REMOVE;
                        cnt_in   = cnt_ff - CNT_W'(1);
                     end
                  end
                  ilist_pkg::CMD_REPLACE: begin
                     if (!req_pos_ok) begin
                        rsp_status_in = ilist_pkg::STATUS_RANGE;
                     end else begin
                        ctl.mode = ilist_pkg::CELL_WRITE;
                     end
                  end
                  ilist_pkg::CMD_READ: begin
                     if (!req_pos_ok) begin
                        rsp_status_in = ilist_pkg::STATUS_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  ilist_pkg::CMD_SWAP: begin
                     if (!req_pos_ok || !req_pos2_ok) begin
                        rsp_status_in = ilist_pkg::STATUS_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  ilist_pkg::CMD_FIND: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  ilist_pkg::CMD_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                     cnt_in = cnt_ff;
                  end
               endcase

               rsp_count_in    = ilist_pkg::COUNT_W'(cnt_in);
               rsp_is_empty_in = (cnt_in == '0);
            end
         end

         ST_SCAN: begin
            // entry number step_ff sits in the head cell this cycle
            ctl.mode = ilist_pkg::CELL_ROTATE;
            if (step_w == pos_w) begin
               a_in = head;
            end
            if (step_w == pos2_w) begin
               b_in = head;
            end
            if ((step_w < cnt_w) && (head == value_ff)) begin
               found_in = 1'b1;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // chain is back in order; swap writes both slots at once
            ctl.position       = pos_ff;
            ctl.other_position = pos2_ff;
            ctl.wr_a           = b_ff;
            ctl.wr_b           = a_ff;
            ctl.wr_b_en        = 1'b1;
            if (cmd_ff == ilist_pkg::CMD_SWAP) begin
               ctl.mode = ilist_pkg::CELL_WRITE;
            end

            rsp_valid_in      = 1'b1;
            rsp_read_value_in = (cmd_ff == ilist_pkg::CMD_READ) ? a_ff : '0;
            rsp_found_in      = (cmd_ff == ilist_pkg::CMD_FIND) ? found_ff : 1'b0;
            rsp_status_in     = ilist_pkg::STATUS_OK;
            rsp_count_in      = cnt_w[ilist_pkg::COUNT_W-1:0];
            rsp_is_empty_in   = (cnt_ff == '0);
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff           <= step_in;
      cmd_ff            <= cmd_in;
      pos_ff            <= pos_in;
      pos2_ff           <= pos2_in;
      value_ff          <= value_in;
      a_ff              <= a_in;
      b_ff              <= b_in;
      found_ff          <= found_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_is_empty_ff   <= rsp_is_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;

endmodule

`default_nettype wire
